// ===== hdl/eight_bit_alu_execute_unit_defines.svh =====
// Assertion macros for the eight-bit ALU execute unit.
// No dependencies; taken in by the top level.
`ifndef EIGHT_BIT_ALU_EXECUTE_UNIT_DEFINES_SVH
`define EIGHT_BIT_ALU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication under reset
`define EBA_ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("execute unit check failed");

// next-cycle implication under reset
`define EBA_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("execute unit check failed");

`endif

// ===== hdl/eba_pkg.sv =====
// Shared types and codes for the eight-bit ALU execute unit.
// No dependencies.
package eba_pkg;

	typedef enum logic [5:0] {
		OP_LDA, OP_LDX, OP_LDY,
		OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
		OP_AND, OP_EOR, OP_ORA, OP_BIT,
		OP_ADC, OP_SBC,
		OP_CMP, OP_CPX, OP_CPY,
		OP_INC, OP_INX, OP_INY, OP_DEC, OP_DEX, OP_DEY,
		OP_ASL, OP_LSR, OP_ROL, OP_ROR,
		OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI,
		OP_BRANCH,
		OP_STA, OP_STX, OP_STY
	} op_t;

	localparam logic [7:0] SIGN_MASK = 8'h80;
	localparam logic [7:0] BYTE_ONES = 8'hFF;
	localparam logic [7:0] SP_RESET  = 8'hFD;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic       c;
		logic       z;
		logic       i;
		logic       d;
		logic       v;
		logic       n;
	} arch_t;

	typedef struct packed {
		logic [5:0]        operation;
		logic [7:0]        operand;
		logic              on_accumulator;
		logic [15:0]       access_address;
		logic [15:0]       current_pc;
		logic signed [7:0] branch_offset;
		logic [2:0]        branch_condition;
	} item_t;

	typedef struct packed {
		logic [7:0]  acc_out;
		logic [7:0]  index_x_out;
		logic [7:0]  index_y_out;
		logic [7:0]  stack_ptr_out;
		logic [7:0]  status_out;
		logic        mem_write;
		logic [7:0]  mem_data;
		logic [15:0] mem_address;
		logic        branch_taken;
		logic [15:0] next_pc;
		logic [1:0]  extra_cycles;
	} result_t;

	localparam arch_t ARCH_RESET = '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET,
		c: 1'b0, z: 1'b0, i: 1'b1, d: 1'b0, v: 1'b0, n: 1'b0};

endpackage

// ===== hdl/eight_bit_alu_execute_unit.sv =====
// Execute stage top level: input register, ALU pass, register file, result register.
// Depends on eba_pkg, eba_alu and eight_bit_alu_execute_unit_defines.svh.
//
//  channel  handshake                 payload
//  item     item_valid / item_stall   operation .. branch_condition
//  result   result_valid / result_stall  acc_out .. extra_cycles
//
// One item per clock while the result is not stalled; an item passes the input register,
// then the ALU pass into the result register and A/X/Y/SP/flags.
// The register file is the only loop: each item sees the state left by the one before.
// Reset: A, X, Y zero, SP 0xFD, flags clear but I; both stages empty.
// A stalled result holds; the input keeps taking items until its register is full.
`include "eight_bit_alu_execute_unit_defines.svh"

module eight_bit_alu_execute_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [5:0]        operation,
	input  logic [7:0]        operand,
	input  logic              on_accumulator,
	input  logic [15:0]       access_address,
	input  logic [15:0]       current_pc,
	input  logic signed [7:0] branch_offset,
	input  logic [2:0]        branch_condition,
	output logic              result_valid,
	input  logic              result_stall,
	output logic [7:0]        acc_out,
	output logic [7:0]        index_x_out,
	output logic [7:0]        index_y_out,
	output logic [7:0]        stack_ptr_out,
	output logic [7:0]        status_out,
	output logic              mem_write,
	output logic [7:0]        mem_data,
	output logic [15:0]       mem_address,
	output logic              branch_taken,
	output logic [15:0]       next_pc,
	output logic [1:0]        extra_cycles
);
	import eba_pkg::*;

	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	arch_t   arch_q;
	arch_t   arch_n;
	result_t res_n;
	logic    advance;
	logic    item_xfer;

	assign advance    = valid_s1 & (~valid_s2 | ~result_stall);
	assign item_stall = valid_s1 & ~advance;
	assign item_xfer  = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			item_s1 <= '{operation: operation, operand: operand,
				on_accumulator: on_accumulator, access_address: access_address,
				current_pc: current_pc, branch_offset: branch_offset,
				branch_condition: branch_condition};
		end
	end

	eba_alu u_alu (
		.cur  (arch_q),
		.item (item_s1),
		.nxt  (arch_n),
		.res  (res_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arch_q   <= ARCH_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				arch_q   <= arch_n;
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign result_valid  = valid_s2;
	assign acc_out       = res_s2.acc_out;
	assign index_x_out   = res_s2.index_x_out;
	assign index_y_out   = res_s2.index_y_out;
	assign stack_ptr_out = res_s2.stack_ptr_out;
	assign status_out    = res_s2.status_out;
	assign mem_write     = res_s2.mem_write;
	assign mem_data      = res_s2.mem_data;
	assign mem_address   = res_s2.mem_address;
	assign branch_taken  = res_s2.branch_taken;
	assign next_pc       = res_s2.next_pc;
	assign extra_cycles  = res_s2.extra_cycles;

	// a held item waits only behind a stalled result
	`EBA_ASSERT_IMPL(a_stall_cause, clk, arst_n, item_stall, valid_s1 && valid_s2 && result_stall)
	// registers move only when an item passes the ALU
	`EBA_ASSERT_NEXT(a_arch_hold, clk, arst_n, !advance, $stable(arch_q))
	// extra cycles only on a taken branch
	`EBA_ASSERT_IMPL(a_extra_taken, clk, arst_n, result_valid && extra_cycles != 2'd0,
		branch_taken)

endmodule

// ===== hdl/eba_alu.sv =====
// Single-pass ALU and flag logic: next register state and result for one item.
// Depends on eba_pkg.
module eba_alu (
	input  eba_pkg::arch_t   cur,
	input  eba_pkg::item_t   item,
	output eba_pkg::arch_t   nxt,
	output eba_pkg::result_t res
);
	import eba_pkg::*;

	logic [7:0]  m;
	logic [7:0]  addend;
	logic [8:0]  sum;
	logic [7:0]  cmp_reg;
	logic [8:0]  diff;
	logic [7:0]  shl;
	logic [7:0]  shr;
	logic [7:0]  shift_res;
	logic        nz_en;
	logic [7:0]  nz_val;
	logic        wr;
	logic [7:0]  wdata;
	logic        taken;
	logic        cond_flag;
	logic [15:0] target;
	logic [1:0]  extra;
	arch_t       st;

	assign m = item.operand;

	// shared adder for ADC and SBC; SBC adds the complement
	assign addend = (op_t'(item.operation) == OP_SBC) ? ~m : m;
	assign sum    = {1'b0, cur.a} + {1'b0, addend} + {8'h00, cur.c};

	always_comb begin
		case (op_t'(item.operation))
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.a;
		endcase
	end
	assign diff = {1'b0, cmp_reg} - {1'b0, m};

	// ROL/ROR feed the old carry in
	assign shl = {m[6:0], (op_t'(item.operation) == OP_ROL) & cur.c};
	assign shr = {(op_t'(item.operation) == OP_ROR) & cur.c, m[7:1]};
	assign shift_res = (op_t'(item.operation) == OP_ASL ||
		op_t'(item.operation) == OP_ROL) ? shl : shr;

	always_comb begin
		case (item.branch_condition[2:1])
			2'd0:    cond_flag = cur.c;
			2'd1:    cond_flag = cur.z;
			2'd2:    cond_flag = cur.n;
			default: cond_flag = cur.v;
		endcase
	end
	assign target = item.current_pc + {{8{item.branch_offset[7]}}, item.branch_offset};

	always_comb begin
		st     = cur;
		nz_en  = 1'b0;
		nz_val = 8'h00;
		wr     = 1'b0;
		wdata  = 8'h00;
		taken  = 1'b0;
		extra  = 2'd0;
		unique case (op_t'(item.operation))
			OP_LDA: begin st.a = m; nz_en = 1'b1; nz_val = m; end
			OP_LDX: begin st.x = m; nz_en = 1'b1; nz_val = m; end
			OP_LDY: begin st.y = m; nz_en = 1'b1; nz_val = m; end
			OP_TAX: begin st.x = cur.a; nz_en = 1'b1; nz_val = cur.a; end
			OP_TAY: begin st.y = cur.a; nz_en = 1'b1; nz_val = cur.a; end
			OP_TXA: begin st.a = cur.x; nz_en = 1'b1; nz_val = cur.x; end
			OP_TYA: begin st.a = cur.y; nz_en = 1'b1; nz_val = cur.y; end
			OP_TSX: begin st.x = cur.sp; nz_en = 1'b1; nz_val = cur.sp; end
			OP_TXS: begin st.sp = cur.x; end
			OP_AND: begin st.a = cur.a & m; nz_en = 1'b1; nz_val = cur.a & m; end
			OP_EOR: begin st.a = cur.a ^ m; nz_en = 1'b1; nz_val = cur.a ^ m; end
			OP_ORA: begin st.a = cur.a | m; nz_en = 1'b1; nz_val = cur.a | m; end
			OP_BIT: begin
				st.z = ((cur.a & m) == 8'h00);
				st.v = m[6];
				st.n = m[7];
			end
			OP_ADC: begin
				st.a   = sum[7:0];
				st.c   = sum[8];
				st.v   = ~(cur.a[7] ^ m[7]) & (cur.a[7] ^ sum[7]);
				nz_en  = 1'b1;
				nz_val = sum[7:0];
			end
			OP_SBC: begin
				st.a   = sum[7:0];
				st.c   = sum[8];
				st.v   = (cur.a[7] ^ m[7]) & (cur.a[7] ^ sum[7]);
				nz_en  = 1'b1;
				nz_val = sum[7:0];
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				st.c   = ~diff[8];
				nz_en  = 1'b1;
				nz_val = diff[7:0];
			end
			OP_INC: begin
				wr = 1'b1; wdata = m + 8'h01; nz_en = 1'b1; nz_val = m + 8'h01;
			end
			OP_DEC: begin
				wr = 1'b1; wdata = m + BYTE_ONES; nz_en = 1'b1; nz_val = m + BYTE_ONES;
			end
			OP_INX: begin st.x = cur.x + 8'h01; nz_en = 1'b1; nz_val = cur.x + 8'h01; end
			OP_INY: begin st.y = cur.y + 8'h01; nz_en = 1'b1; nz_val = cur.y + 8'h01; end
			OP_DEX: begin st.x = cur.x + BYTE_ONES; nz_en = 1'b1; nz_val = cur.x + BYTE_ONES; end
			OP_DEY: begin st.y = cur.y + BYTE_ONES; nz_en = 1'b1; nz_val = cur.y + BYTE_ONES; end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				st.c = (op_t'(item.operation) == OP_ASL ||
					op_t'(item.operation) == OP_ROL) ? m[7] : m[0];
				nz_en  = 1'b1;
				nz_val = shift_res;
				if (item.on_accumulator) begin
					st.a = shift_res;
				end else begin
					wr    = 1'b1;
					wdata = shift_res;
				end
			end
			OP_CLC: st.c = 1'b0;
			OP_CLD: st.d = 1'b0;
			OP_CLI: st.i = 1'b0;
			OP_CLV: st.v = 1'b0;
			OP_SEC: st.c = 1'b1;
			OP_SED: st.d = 1'b1;
			OP_SEI: st.i = 1'b1;
			OP_BRANCH: begin
				// not-equal/equal test Z, the rest test their flag; bit 0 picks set
				taken = (cond_flag == item.branch_condition[0]);
				if (taken) begin
					extra = (target[15:8] != item.current_pc[15:8]) ? 2'd2 : 2'd1;
				end
			end
			OP_STA: begin wr = 1'b1; wdata = cur.a; end
			OP_STX: begin wr = 1'b1; wdata = cur.x; end
			OP_STY: begin wr = 1'b1; wdata = cur.y; end
			default: ;
		endcase
		if (nz_en) begin
			st.z = (nz_val == 8'h00);
			st.n = nz_val[7];
		end
	end

	assign nxt = st;

	always_comb begin
		res.acc_out       = st.a;
		res.index_x_out   = st.x;
		res.index_y_out   = st.y;
		res.stack_ptr_out = st.sp;
		res.status_out    = {st.n, st.v, 1'b1, 1'b0, st.d, st.i, st.z, st.c};
		res.mem_write     = wr;
		res.mem_data      = wr ? wdata : 8'h00;
		res.mem_address   = wr ? item.access_address : 16'h0000;
		res.branch_taken  = taken;
		res.next_pc       = taken ? target : item.current_pc;
		res.extra_cycles  = extra;
	end

endmodule

// ===== sim/tb_eight_bit_alu_execute_unit.sv =====
// Self-checking testbench for the eight-bit ALU execute unit: directed and random
// instructions under varied idle and stall patterns. Depends on eba_pkg and the RTL top level.
module tb_eight_bit_alu_execute_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import eba_pkg::*;

	typedef enum logic [2:0] {
		COND_CC, COND_CS, COND_NE, COND_EQ, COND_PL, COND_MI, COND_VC, COND_VS
	} cond_t;

	localparam logic [5:0] OP_UNUSED_TOP = 6'h3F;
	localparam int ITEMS_PER_PHASE = 100;

	class exec_checker;
		arch_t regs = ARCH_RESET;
		result_t due_results[$];
		int errors = 0;

		function void set_nz(logic [7:0] val);
			regs.z = (val == 8'h00);
			regs.n = val[7];
		endfunction

		function logic [7:0] add_carry(logic [7:0] acc, logic [7:0] m, logic sub);
			logic [7:0] addend, sum8, ovf;
			logic [8:0] sum;
			addend = sub ? (m ^ BYTE_ONES) : m;
			sum = {1'b0, acc} + {1'b0, addend} + {8'h00, regs.c};
			sum8 = sum[7:0];
			regs.c = sum[8];
			ovf = sub ? ((acc ^ m) & (acc ^ sum8)) : (~(acc ^ m) & (acc ^ sum8));
			regs.v = ovf[7];
			set_nz(sum8);
			return sum8;
		endfunction

		function void compare_reg(logic [7:0] rv, logic [7:0] m);
			regs.c = (rv >= m);
			set_nz(rv - m);
		endfunction

		function void note_item(item_t it);
			result_t r;
			logic [7:0] m, shifted;
			logic old_c, taken;
			m = it.operand;
			r = '0;
			r.next_pc = it.current_pc;
			case (it.operation)
				OP_LDA: begin regs.a = m; set_nz(m); end
				OP_LDX: begin regs.x = m; set_nz(m); end
				OP_LDY: begin regs.y = m; set_nz(m); end
				OP_TAX: begin regs.x = regs.a; set_nz(regs.x); end
				OP_TAY: begin regs.y = regs.a; set_nz(regs.y); end
				OP_TXA: begin regs.a = regs.x; set_nz(regs.a); end
				OP_TYA: begin regs.a = regs.y; set_nz(regs.a); end
				OP_TSX: begin regs.x = regs.sp; set_nz(regs.x); end
				OP_TXS: regs.sp = regs.x;
				OP_AND: begin regs.a = regs.a & m; set_nz(regs.a); end
				OP_EOR: begin regs.a = regs.a ^ m; set_nz(regs.a); end
				OP_ORA: begin regs.a = regs.a | m; set_nz(regs.a); end
				OP_BIT: begin
					regs.z = ((regs.a & m) == 8'h00);
					regs.v = m[6];
					regs.n = m[7];
				end
				OP_ADC: regs.a = add_carry(regs.a, m, 1'b0);
				OP_SBC: regs.a = add_carry(regs.a, m, 1'b1);
				OP_CMP: compare_reg(regs.a, m);
				OP_CPX: compare_reg(regs.x, m);
				OP_CPY: compare_reg(regs.y, m);
				OP_INC: begin r.mem_write = 1'b1; r.mem_data = m + 8'h01; set_nz(r.mem_data); end
				OP_INX: begin regs.x = regs.x + 8'h01; set_nz(regs.x); end
				OP_INY: begin regs.y = regs.y + 8'h01; set_nz(regs.y); end
				OP_DEC: begin r.mem_write = 1'b1; r.mem_data = m - 8'h01; set_nz(r.mem_data); end
				OP_DEX: begin regs.x = regs.x - 8'h01; set_nz(regs.x); end
				OP_DEY: begin regs.y = regs.y - 8'h01; set_nz(regs.y); end
				OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
					old_c = regs.c;
					if (it.operation == OP_ASL || it.operation == OP_ROL) begin
						regs.c = m[7];
						shifted = {m[6:0], (it.operation == OP_ROL) && old_c};
					end else begin
						regs.c = m[0];
						shifted = {(it.operation == OP_ROR) && old_c, m[7:1]};
					end
					set_nz(shifted);
					if (it.on_accumulator) begin
						regs.a = shifted;
					end else begin
						r.mem_write = 1'b1;
						r.mem_data = shifted;
					end
				end
				OP_CLC: regs.c = 1'b0;
				OP_CLD: regs.d = 1'b0;
				OP_CLI: regs.i = 1'b0;
				OP_CLV: regs.v = 1'b0;
				OP_SEC: regs.c = 1'b1;
				OP_SED: regs.d = 1'b1;
				OP_SEI: regs.i = 1'b1;
				OP_BRANCH: begin
					case (it.branch_condition)
						COND_CC: taken = !regs.c;
						COND_CS: taken = regs.c;
						COND_NE: taken = !regs.z;
						COND_EQ: taken = regs.z;
						COND_PL: taken = !regs.n;
						COND_MI: taken = regs.n;
						COND_VC: taken = !regs.v;
						default: taken = regs.v;
					endcase
					if (taken) begin
						r.branch_taken = 1'b1;
						r.next_pc = it.current_pc + {{8{it.branch_offset[7]}}, it.branch_offset};
						r.extra_cycles = (r.next_pc[15:8] != it.current_pc[15:8]) ? 2'd2 : 2'd1;
					end
				end
				OP_STA: begin r.mem_write = 1'b1; r.mem_data = regs.a; end
				OP_STX: begin r.mem_write = 1'b1; r.mem_data = regs.x; end
				OP_STY: begin r.mem_write = 1'b1; r.mem_data = regs.y; end
				default: ;
			endcase
			if (r.mem_write)
				r.mem_address = it.access_address;
			r.acc_out = regs.a;
			r.index_x_out = regs.x;
			r.index_y_out = regs.y;
			r.stack_ptr_out = regs.sp;
			r.status_out = {regs.n, regs.v, 1'b1, 1'b0, regs.d, regs.i, regs.z, regs.c};
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("result transfer with nothing outstanding");
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("acc_out", 16'(want.acc_out), 16'(got.acc_out));
			compare_field("index_x_out", 16'(want.index_x_out), 16'(got.index_x_out));
			compare_field("index_y_out", 16'(want.index_y_out), 16'(got.index_y_out));
			compare_field("stack_ptr_out", 16'(want.stack_ptr_out), 16'(got.stack_ptr_out));
			compare_field("status_out", 16'(want.status_out), 16'(got.status_out));
			compare_field("mem_write", 16'(want.mem_write), 16'(got.mem_write));
			compare_field("mem_data", 16'(want.mem_data), 16'(got.mem_data));
			compare_field("mem_address", want.mem_address, got.mem_address);
			compare_field("branch_taken", 16'(want.branch_taken), 16'(got.branch_taken));
			compare_field("next_pc", want.next_pc, got.next_pc);
			compare_field("extra_cycles", 16'(want.extra_cycles), 16'(got.extra_cycles));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [5:0]        operation = '0;
	logic [7:0]        operand = '0;
	logic              on_accumulator = 1'b0;
	logic [15:0]       access_address = '0;
	logic [15:0]       current_pc = '0;
	logic signed [7:0] branch_offset = '0;
	logic [2:0]        branch_condition = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [7:0]        acc_out, index_x_out, index_y_out, stack_ptr_out, status_out;
	logic              mem_write, branch_taken;
	logic [7:0]        mem_data;
	logic [15:0]       mem_address, next_pc;
	logic [1:0]        extra_cycles;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	exec_checker sb = new();

	eight_bit_alu_execute_unit u_top (.*);

	always #5 clk = ~clk;

	// note each input transfer; values read here are those before the edge
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			sb.note_item('{operation, operand, on_accumulator, access_address,
				current_pc, branch_offset, branch_condition});
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result('{acc_out, index_x_out, index_y_out, stack_ptr_out, status_out,
				mem_write, mem_data, mem_address, branch_taken, next_pc, extra_cycles});
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic item_t mk(logic [5:0] op, logic [7:0] m, logic on_acc = 1'b0,
			logic [15:0] addr = 16'h0000, logic [15:0] pc = 16'h0000,
			logic [7:0] off = 8'h00, cond_t cond = COND_CC);
		return '{op, m, on_acc, addr, pc, off, cond};
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			it.operation = 6'($urandom_range(OP_UNUSED_TOP, OP_STY + 1));
		else if (pick < 17)
			it.operation = OP_BRANCH;
		else
			it.operation = 6'($urandom_range(OP_STY));
		pick = $urandom_range(99);
		if (pick < 8)
			it.operand = 8'h00;
		else if (pick < 16)
			it.operand = BYTE_ONES;
		else if (pick < 20)
			it.operand = SIGN_MASK;
		else if (pick < 30)
			it.operand = sb.regs.a;	// gives equal CMP compares and BIT tests of A against itself
		else
			it.operand = 8'($urandom);
		it.on_accumulator = 1'($urandom);
		it.access_address = 16'($urandom);
		it.current_pc = 16'($urandom);
		it.branch_offset = 8'($urandom);
		it.branch_condition = 3'($urandom);
		return it;
	endfunction

	task automatic send_item(item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= it.operation;
		operand <= it.operand;
		on_accumulator <= it.on_accumulator;
		access_address <= it.access_address;
		current_pc <= it.current_pc;
		branch_offset <= it.branch_offset;
		branch_condition <= it.branch_condition;
		do @(posedge clk); while (item_stall);
	endtask

	// hold the sender off until every outstanding result has been transferred
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		item_t directed[$];
		int idle_set[4] = '{0, 73, 0, 10};
		int stall_set[4] = '{0, 0, 73, 10};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			mk(OP_LDA, 8'h00), mk(OP_LDA, BYTE_ONES), mk(OP_TAX, 8'h00),
			mk(OP_TXS, 8'h00), mk(OP_TSX, 8'h00), mk(OP_LDA, 8'h7F),
			mk(OP_CLC, 8'h00), mk(OP_ADC, 8'h01), mk(OP_SEC, 8'h00),
			mk(OP_SBC, 8'h01), mk(OP_CMP, 8'h7F), mk(OP_BIT, 8'hC0),
			mk(OP_BRANCH, 8'h00, 1'b0, 16'h0000, 16'h10F0, 8'h7F, COND_VS),
			mk(OP_BRANCH, 8'h00, 1'b0, 16'h0000, 16'hFFFF, 8'h01, COND_VC),
			mk(OP_BRANCH, 8'h00, 1'b0, 16'h0000, 16'h0000, SIGN_MASK, COND_CS),
			mk(OP_BRANCH, 8'h00, 1'b0, 16'h0000, 16'h1234, 8'h10, COND_NE),
			mk(OP_INC, BYTE_ONES, 1'b0, 16'hFFFF), mk(OP_DEC, 8'h00, 1'b0, 16'h0000),
			mk(OP_ROR, 8'h01, 1'b1), mk(OP_ASL, SIGN_MASK, 1'b0, 16'hA5A5),
			mk(OP_SED, 8'h00), mk(OP_CLD, 8'h00),
			mk(OP_STA, 8'h00, 1'b0, 16'hFFFF), mk(OP_UNUSED_TOP, BYTE_ONES, 1'b1, 16'hFFFF)
		};
		foreach (directed[k])
			send_item(directed[k]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			repeat (ITEMS_PER_PHASE)
				send_item(random_item());
			drain();
		end

		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/eba_pkg.sv
hdl/eba_alu.sv
hdl/eight_bit_alu_execute_unit.sv
sim/tb_eight_bit_alu_execute_unit.sv
